### rtl/euler_to_rotation_matrix_core_macros.svh
// Assertion macros shared by the RTL of the rotation matrix core.
`ifndef EULER_TO_ROTATION_MATRIX_CORE_MACROS_SVH
`define EULER_TO_ROTATION_MATRIX_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define E2R_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define E2R_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define E2R_ASSERT_IMPL(label, ante, cons, msg)

`define E2R_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/e2r_pkg.sv
`timescale 1ns / 1ps

package e2r_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam int OUT_FRAC = 14;
    localparam int LANE_EXTRA_LATENCY = 2;
    localparam int MERGE_LATENCY = 5;

    localparam logic [31:0] CORDIC_GAIN = 32'h9B74EDA8;

    localparam logic signed [15:0] OUT_LIMIT = 16'sd16384;
    localparam logic signed [15:0] OUT_LIMIT_NEG = -16'sd16384;

    localparam logic [31:0] ATAN_TURN [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

### rtl/euler_to_rotation_matrix_core.sv
// An accepted transaction passes through the CORDIC lanes and then the product stages to its result.
// Throughput is one transaction per cycle: three CORDIC lanes and the product stages
// are fully pipelined, and the whole pipeline holds only while a result is stalled.
// Reset clears the valid bits of the pipeline; the data registers are not reset.
`timescale 1ns / 1ps
`include "euler_to_rotation_matrix_core_macros.svh"

module euler_to_rotation_matrix_core #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRACTION_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] roll_angle,
    input  logic signed [15:0] pitch_angle,
    input  logic signed [15:0] yaw_angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22
);

    localparam int W = FRACTION_BITS + 3;
    localparam int NSTG = (CORDIC_STAGES > e2r_pkg::ATAN_ENTRIES) ?
                          e2r_pkg::ATAN_ENTRIES : CORDIC_STAGES;
    localparam int DEPTH = NSTG + e2r_pkg::LANE_EXTRA_LATENCY + e2r_pkg::MERGE_LATENCY;

    logic                adv;
    logic [DEPTH-1:0]    vld_reg;
    logic [DEPTH-1:0]    vld_next;
    logic signed [W-1:0] sr, cr, sp, cp, sy, cy;

    assign adv = !vld_reg[DEPTH-1] || !out_stall;
    assign in_stall = !adv;
    assign out_valid = vld_reg[DEPTH-1];
    assign vld_next = {vld_reg[DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    e2r_cordic_lane #(
        .CORDIC_STAGES(CORDIC_STAGES),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_roll_lane (
        .clk    (clk),
        .en     (adv),
        .angle  (roll_angle),
        .sin_val(sr),
        .cos_val(cr)
    );

    e2r_cordic_lane #(
        .CORDIC_STAGES(CORDIC_STAGES),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_pitch_lane (
        .clk    (clk),
        .en     (adv),
        .angle  (pitch_angle),
        .sin_val(sp),
        .cos_val(cp)
    );

    e2r_cordic_lane #(
        .CORDIC_STAGES(CORDIC_STAGES),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_yaw_lane (
        .clk    (clk),
        .en     (adv),
        .angle  (yaw_angle),
        .sin_val(sy),
        .cos_val(cy)
    );

    e2r_merge #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_merge (
        .clk(clk),
        .en (adv),
        .sr (sr),
        .cr (cr),
        .sp (sp),
        .cp (cp),
        .sy (sy),
        .cy (cy),
        .m00(m00),
        .m01(m01),
        .m02(m02),
        .m10(m10),
        .m11(m11),
        .m12(m12),
        .m20(m20),
        .m21(m21),
        .m22(m22)
    );

    `E2R_ASSERT_IMPL(a_out_from_pipe, $rose(out_valid), $past(vld_reg[DEPTH-2]),
        "result without a transaction behind it")
    `E2R_ASSERT_NEXT(a_out_drains, out_valid && !out_stall && !vld_reg[DEPTH-2],
        !out_valid, "result repeated after it was taken")
    `E2R_ASSERT_IMPL(a_row0_range, out_valid,
        m00 <= e2r_pkg::OUT_LIMIT && m00 >= e2r_pkg::OUT_LIMIT_NEG &&
        m01 <= e2r_pkg::OUT_LIMIT && m01 >= e2r_pkg::OUT_LIMIT_NEG &&
        m02 <= e2r_pkg::OUT_LIMIT && m02 >= e2r_pkg::OUT_LIMIT_NEG,
        "row 0 entry out of range")
    `E2R_ASSERT_IMPL(a_row2_range, out_valid,
        m20 <= e2r_pkg::OUT_LIMIT && m20 >= e2r_pkg::OUT_LIMIT_NEG &&
        m21 <= e2r_pkg::OUT_LIMIT && m21 >= e2r_pkg::OUT_LIMIT_NEG &&
        m22 <= e2r_pkg::OUT_LIMIT && m22 >= e2r_pkg::OUT_LIMIT_NEG,
        "row 2 entry out of range")

endmodule

### rtl/e2r_cordic_lane.sv
`timescale 1ns / 1ps

module e2r_cordic_lane #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRACTION_BITS = 14
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [15:0]              angle,
    output logic signed [FRACTION_BITS+2:0] sin_val,
    output logic signed [FRACTION_BITS+2:0] cos_val
);

    localparam int W = FRACTION_BITS + 3;
    localparam int ZW = 33;
    localparam int NSTG = (CORDIC_STAGES > e2r_pkg::ATAN_ENTRIES) ?
                          e2r_pkg::ATAN_ENTRIES : CORDIC_STAGES;
    localparam logic [63:0] X0_FULL =
        ((64'(e2r_pkg::CORDIC_GAIN) << FRACTION_BITS) + 64'h80000000) >> 32;
    localparam logic signed [W-1:0] X0 = X0_FULL[W-1:0];

    logic signed [W-1:0]  x_reg [0:NSTG];
    logic signed [W-1:0]  y_reg [0:NSTG];
    logic signed [ZW-1:0] z_reg [0:NSTG];
    logic                 flip_reg [0:NSTG];
    logic signed [W-1:0]  sin_reg;
    logic signed [W-1:0]  cos_reg;
    logic                 flip_next;
    logic signed [ZW-1:0] z_next;

    // An angle in the left half plane is turned by half a turn, so the
    // rotation only ever sees angles between minus and plus a quarter turn.
    always_comb
    begin
        flip_next = angle[15] ^ angle[14];
        z_next = {angle[14], angle[14], angle[14:0], 16'h0000};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= X0;
            y_reg[0] <= '0;
            z_reg[0] <= z_next;
            flip_reg[0] <= flip_next;
            for (int i = 0; i < NSTG; i++)
            begin
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ZW'(e2r_pkg::ATAN_TURN[i]);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ZW'(e2r_pkg::ATAN_TURN[i]);
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= flip_reg[NSTG] ? -x_reg[NSTG] : x_reg[NSTG];
            sin_reg <= flip_reg[NSTG] ? -y_reg[NSTG] : y_reg[NSTG];
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

### rtl/e2r_merge.sv
`timescale 1ns / 1ps

module e2r_merge #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [FRACTION_BITS+2:0] sr,
    input  logic signed [FRACTION_BITS+2:0] cr,
    input  logic signed [FRACTION_BITS+2:0] sp,
    input  logic signed [FRACTION_BITS+2:0] cp,
    input  logic signed [FRACTION_BITS+2:0] sy,
    input  logic signed [FRACTION_BITS+2:0] cy,
    output logic signed [15:0]              m00,
    output logic signed [15:0]              m01,
    output logic signed [15:0]              m02,
    output logic signed [15:0]              m10,
    output logic signed [15:0]              m11,
    output logic signed [15:0]              m12,
    output logic signed [15:0]              m20,
    output logic signed [15:0]              m21,
    output logic signed [15:0]              m22
);

    localparam int F = FRACTION_BITS;
    localparam int W = F + 3;
    localparam int W1 = W + 1;
    localparam int PW = 2 * W;
    localparam int PW1 = PW + 1;
    localparam int SW = PW + 1;
    localparam int RW = SW + 1;
    localparam int SH = 2 * F - e2r_pkg::OUT_FRAC;

    localparam logic signed [PW:0]   HALF_F = PW1'(64'd1 << (F - 1));
    localparam logic signed [RW-1:0] HALF_S = RW'(64'd1 << (SH - 1));
    localparam logic signed [RW-1:0] LIM_R = RW'(e2r_pkg::OUT_LIMIT);
    localparam logic signed [RW-1:0] LIM_NEG_R = RW'(e2r_pkg::OUT_LIMIT_NEG);

    function automatic logic signed [15:0] sat_q14(input logic signed [SW-1:0] v);
        logic signed [RW-1:0] r;
        r = (RW'(v) + HALF_S) >>> SH;
        if (r > LIM_R)
            r = LIM_R;
        else if (r < LIM_NEG_R)
            r = LIM_NEG_R;
        return r[15:0];
    endfunction

    // First step: the nested products.
    logic signed [W-1:0]  sr1_reg, cr1_reg, sp1_reg, cp1_reg, sy1_reg, cy1_reg;
    logic signed [PW-1:0] spcy1_reg, spsy1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr1_reg <= sr;
            cr1_reg <= cr;
            sp1_reg <= sp;
            cp1_reg <= cp;
            sy1_reg <= sy;
            cy1_reg <= cy;
            spcy1_reg <= sp * cy;
            spsy1_reg <= sp * sy;
        end
    end

    // Second step: the nested products go back to the CORDIC fraction width.
    logic signed [W-1:0] sr2_reg, cr2_reg, sp2_reg, cp2_reg, sy2_reg, cy2_reg;
    logic signed [W-1:0] spcy2_reg, spsy2_reg;
    logic signed [PW:0]  spcy_full, spsy_full;

    always_comb
    begin
        spcy_full = (PW1'(spcy1_reg) + HALF_F) >>> F;
        spsy_full = (PW1'(spsy1_reg) + HALF_F) >>> F;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr2_reg <= sr1_reg;
            cr2_reg <= cr1_reg;
            sp2_reg <= sp1_reg;
            cp2_reg <= cp1_reg;
            sy2_reg <= sy1_reg;
            cy2_reg <= cy1_reg;
            spcy2_reg <= spcy_full[W-1:0];
            spsy2_reg <= spsy_full[W-1:0];
        end
    end

    // Third step: every product of the matrix entries.
    logic signed [PW-1:0] t00_reg, t01a_reg, t01b_reg, t02a_reg, t02b_reg, t10_reg;
    logic signed [PW-1:0] t11a_reg, t11b_reg, t12a_reg, t12b_reg, t21_reg, t22_reg;
    logic signed [W-1:0]  sp3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t00_reg <= cp2_reg * cy2_reg;
            t01a_reg <= cr2_reg * sy2_reg;
            t01b_reg <= sr2_reg * spcy2_reg;
            t02a_reg <= sr2_reg * sy2_reg;
            t02b_reg <= cr2_reg * spcy2_reg;
            t10_reg <= cp2_reg * sy2_reg;
            t11a_reg <= cr2_reg * cy2_reg;
            t11b_reg <= sr2_reg * spsy2_reg;
            t12a_reg <= sr2_reg * cy2_reg;
            t12b_reg <= cr2_reg * spsy2_reg;
            t21_reg <= sr2_reg * cp2_reg;
            t22_reg <= cr2_reg * cp2_reg;
            sp3_reg <= sp2_reg;
        end
    end

    // Fourth step: the sums.
    logic signed [SW-1:0] s00_reg, s01_reg, s02_reg, s10_reg;
    logic signed [SW-1:0] s11_reg, s12_reg, s21_reg, s22_reg;
    logic signed [W:0]    nsp4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s00_reg <= SW'(t00_reg);
            s01_reg <= SW'(t01b_reg) - SW'(t01a_reg);
            s02_reg <= SW'(t02a_reg) + SW'(t02b_reg);
            s10_reg <= SW'(t10_reg);
            s11_reg <= SW'(t11a_reg) + SW'(t11b_reg);
            s12_reg <= SW'(t12b_reg) - SW'(t12a_reg);
            s21_reg <= SW'(t21_reg);
            s22_reg <= SW'(t22_reg);
            nsp4_reg <= -(W1'(sp3_reg));
        end
    end

    // Fifth step: rounding to Q1.14 and saturation.
    logic signed [15:0] m20_next;

    if (F > e2r_pkg::OUT_FRAC)
    begin : g_m20_round
        localparam int SHF = F - e2r_pkg::OUT_FRAC;
        localparam int NW = W + 2;
        localparam logic signed [NW-1:0] HALF_N = NW'(64'd1 << (SHF - 1));
        localparam logic signed [NW-1:0] LIM_N = NW'(e2r_pkg::OUT_LIMIT);
        localparam logic signed [NW-1:0] LIM_NEG_N = NW'(e2r_pkg::OUT_LIMIT_NEG);
        logic signed [NW-1:0] r;

        always_comb
        begin
            r = (NW'(nsp4_reg) + HALF_N) >>> SHF;
            if (r > LIM_N)
                m20_next = e2r_pkg::OUT_LIMIT;
            else if (r < LIM_NEG_N)
                m20_next = e2r_pkg::OUT_LIMIT_NEG;
            else
                m20_next = r[15:0];
        end
    end
    else
    begin : g_m20_scale
        localparam int SHL = e2r_pkg::OUT_FRAC - F;
        localparam int NW = W + 1 + SHL;
        localparam logic signed [NW-1:0] LIM_N = NW'(e2r_pkg::OUT_LIMIT);
        localparam logic signed [NW-1:0] LIM_NEG_N = NW'(e2r_pkg::OUT_LIMIT_NEG);
        logic signed [NW-1:0] r;

        always_comb
        begin
            r = NW'(nsp4_reg) <<< SHL;
            if (r > LIM_N)
                m20_next = e2r_pkg::OUT_LIMIT;
            else if (r < LIM_NEG_N)
                m20_next = e2r_pkg::OUT_LIMIT_NEG;
            else
                m20_next = r[15:0];
        end
    end

    logic signed [15:0] m00_reg, m01_reg, m02_reg, m10_reg, m11_reg;
    logic signed [15:0] m12_reg, m20_reg, m21_reg, m22_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m00_reg <= sat_q14(s00_reg);
            m01_reg <= sat_q14(s01_reg);
            m02_reg <= sat_q14(s02_reg);
            m10_reg <= sat_q14(s10_reg);
            m11_reg <= sat_q14(s11_reg);
            m12_reg <= sat_q14(s12_reg);
            m20_reg <= m20_next;
            m21_reg <= sat_q14(s21_reg);
            m22_reg <= sat_q14(s22_reg);
        end
    end

    assign m00 = m00_reg;
    assign m01 = m01_reg;
    assign m02 = m02_reg;
    assign m10 = m10_reg;
    assign m11 = m11_reg;
    assign m12 = m12_reg;
    assign m20 = m20_reg;
    assign m21 = m21_reg;
    assign m22 = m22_reg;

endmodule
